### src/glob_wildcard_matcher_macros.svh
// Assertion macros used by the glob matcher back end.
// Depends on a clk and rst signal in the scope that uses them.
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// Same-cycle implication, skipped while in reset.
`define GWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while in reset.
`define GWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Invariant that holds at every edge out of reset.
`define GWM_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

### src/gwm_pkg.sv
// Shared types, constants and helpers for the glob wildcard matcher.
// No dependencies; imported by every module of the block.
package gwm_pkg;

  localparam int GWM_PATTERN_CHARS = 16;
  localparam int GWM_QUEUE_DEPTH   = 2;
  localparam int CHAR_W            = 16;

  localparam logic [CHAR_W-1:0] STAR_CODE     = 16'h002A;
  localparam logic [CHAR_W-1:0] QUESTION_CODE = 16'h003F;
  localparam logic [CHAR_W-1:0] LOWER_A       = 16'h0061;
  localparam logic [CHAR_W-1:0] LOWER_Z       = 16'h007A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET   = 16'h0020;

  typedef enum logic [1:0] {
    ACT_NEW    = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_NAME   = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  // Classified beat as it waits in the queue.
  typedef struct packed {
    action_t           action;
    logic [CHAR_W-1:0] upper;
    logic              is_star;
    logic              is_question;
  } item_t;

  function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
    if (c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

### src/gwm_queue.sv
// Small FIFO of classified beats between the front and back of the matcher.
// Depends on gwm_pkg for item_t.
module gwm_queue
  import gwm_pkg::*;
#(
  parameter int DEPTH = GWM_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/gwm_front.sv
// Front end: takes input beats and classifies them for the queue.
// Depends on gwm_pkg for item_t, action_t and fold_upper.
module gwm_front
  import gwm_pkg::*;
(
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,   // [15:0] character
  input  logic [1:0]        s_tuser,   // [1:0] action
  input  logic              q_full,
  output logic              push,
  output item_t             push_item
);

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // Fold case once here so the back end compares plain codes.
  always_comb begin
    push_item.action      = action_t'(s_tuser);
    push_item.upper       = fold_upper(s_tdata);
    push_item.is_star     = (s_tdata == STAR_CODE);
    push_item.is_question = (s_tdata == QUESTION_CODE);
  end

endmodule

### src/gwm_back.sv
// Back end: pattern store, bit-parallel NFA and the result register.
// Depends on gwm_pkg and the assertion macros header.
`include "glob_wildcard_matcher_macros.svh"

module gwm_back
  import gwm_pkg::*;
#(
  parameter int PATTERN_CHARS = GWM_PATTERN_CHARS
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      head,
  input  logic       empty,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] matched, [7:1] zero
  output logic       m_tuser    // [0] pattern_overflow
);

  localparam int N     = PATTERN_CHARS;
  localparam int LEN_W = $clog2(N + 1);
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(N);

  logic [CHAR_W-1:0] pat_char [N];
  logic [N-1:0]      pat_q;
  logic [N-1:0]      star;
  logic [LEN_W-1:0]  length;
  logic [N:0]        active;
  logic              ovf;
  logic              out_matched;
  logic              out_ovf;

  logic [N-1:0]      valid;
  logic [N:0]        cur;
  logic [N:0]        consumed;
  logic              hit;
  logic              end_pop;

  // Star closure as a parallel prefix: a star position passes activity on.
  function automatic logic [N:0] closure(input logic [N:0] set,
                                         input logic [N-1:0] stars);
    logic [N:0] g;
    logic [N:0] p;
    g = set;
    p = {stars, 1'b0};
    for (int d = 1; d <= N; d = d * 2) begin
      for (int i = N; i >= d; i--) begin
        g[i] = g[i] | (p[i] & g[i-d]);
        p[i] = p[i] & p[i-d];
      end
    end
    return g;
  endfunction

  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid[i] = (LEN_W'(i) < length);
    end
  end

  assign cur = closure(active, star);

  // One NFA step: stars hold, other positions advance on a match.
  always_comb begin
    consumed = '0;
    for (int i = 0; i < N; i++) begin
      if (cur[i] && valid[i]) begin
        if (star[i]) begin
          consumed[i] = 1'b1;
        end else if (pat_q[i] || pat_char[i] == head.upper) begin
          consumed[i+1] = 1'b1;
        end
      end
    end
  end

  assign hit     = !ovf && cur[length];
  assign pop     = !empty && (head.action != ACT_END || !m_tvalid || m_tready);
  assign end_pop = pop && (head.action == ACT_END);

  assign m_tdata = {7'd0, out_matched};
  assign m_tuser = out_ovf;

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (pop && head.action == ACT_APPEND && LEN_W'(i) == length) begin
        pat_char[i] <= head.upper;
        pat_q[i]    <= head.is_question;
      end
    end
    if (end_pop) begin
      out_matched <= hit;
      out_ovf     <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      star     <= '0;
      length   <= '0;
      active   <= (N+1)'(1);
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        unique case (head.action)
          ACT_NEW: begin
            star   <= '0;
            length <= '0;
            ovf    <= 1'b0;
            active <= (N+1)'(1);
          end
          ACT_APPEND: begin
            if (length == FULL_LEN) begin
              ovf <= 1'b1;
            end else begin
              for (int i = 0; i < N; i++) begin
                if (LEN_W'(i) == length) begin
                  star[i] <= head.is_star;
                end
              end
              length <= length + 1'b1;
            end
            active <= (N+1)'(1);
          end
          ACT_NAME: begin
            active <= consumed;
          end
          ACT_END: begin
            active   <= (N+1)'(1);
            m_tvalid <= 1'b1;
          end
          default: begin
            active <= (N+1)'(1);
          end
        endcase
      end
    end
  end

  `GWM_ASSERT_NEXT(a_end_shows_result, end_pop, m_tvalid, "end of name gave no result")
  `GWM_ASSERT_NOW(a_ovf_never_matches, m_tvalid && out_ovf, !out_matched, "match on overflow")
  `GWM_ASSERT_ALWAYS(a_star_in_range, (star & ~valid) == '0, "star bit past pattern end")
  `GWM_ASSERT_NOW(a_no_pop_on_stall, m_tvalid && !m_tready && !empty && head.action == ACT_END,
                  !pop, "end popped over a stalled result")

endmodule

### src/glob_wildcard_matcher.sv
// Top level of the case-insensitive glob matcher ('*' and '?').
// Instantiates gwm_front, gwm_queue and gwm_back; depends on gwm_pkg.
//
// Usage:
//   Input beats arrive on s_*: s_tuser carries the action (new pattern,
//   append pattern character, name character, end of name) and s_tdata the
//   16-bit character. Load a pattern with one "new" beat followed by one
//   "append" beat per character, then stream each name as name-character
//   beats closed by an end-of-name beat.
//   Each end-of-name beat yields one result beat on m_*: m_tdata[0] says
//   whether the whole name matched, m_tuser flags a pattern that overran
//   the store (such patterns never match). No other beat yields a result.
// Timing: one beat is taken every cycle unless the queue is full. A beat is
//   registered in the queue, and the result register loads when its end-of-name
//   beat is popped. The NFA step is a combinational update of the active positions.
// Reset: rst empties the queue, drops any pending result and leaves an
//   empty pattern loaded, so a name matches only if it is empty.
// Stall:
//   When m_tready is low the result register holds; name beats keep
//   flowing until the next end-of-name beat, then the queue fills and
//   s_tready drops.
module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int PATTERN_CHARS = GWM_PATTERN_CHARS,
  parameter int QUEUE_DEPTH   = GWM_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,   // [15:0] character
  input  logic [1:0]        s_tuser,   // [1:0] action
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [0] matched, [7:1] zero
  output logic              m_tuser    // [0] pattern_overflow
);

  item_t push_item;
  item_t head;
  logic  push;
  logic  q_full;
  logic  q_empty;
  logic  pop;

  // Classify incoming beats: fold case, spot the wildcard codes.
  gwm_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple intake from the NFA so a stalled result blocks intake only once the queue fills.
  gwm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // Hold the pattern, advance the NFA and register the result.
  gwm_back #(
    .PATTERN_CHARS (PATTERN_CHARS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for glob_wildcard_matcher: streams pattern and name
// beats, predicts each end-of-name verdict with its own NFA and checks results.
// Depends on gwm_pkg and the glob_wildcard_matcher RTL only.
module testbench;
  import gwm_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int STORE_DEPTH   = GWM_PATTERN_CHARS;
  // Longest legal quiet stretch is the receiver hold-off below plus the time
  // a beat spends in the queue; allow several times that.
  localparam int HOLD_CYCLES   = 400;
  localparam int STUCK_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_BEATS   = 430;
  localparam int MAX_PRINTED   = 100;

  localparam logic [CHAR_W-1:0] MAX_CHAR    = 16'hFFFF;
  localparam logic [CHAR_W-1:0] NUL_CHAR    = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UPPER_C  = 16'h0043;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 16'h005B;
  localparam logic [CHAR_W-1:0] CH_LOWER_B  = 16'h0062;
  localparam logic [CHAR_W-1:0] CH_LOWER_C  = 16'h0063;
  localparam logic [CHAR_W-1:0] CH_LOWER_X  = 16'h0078;

  typedef struct packed {
    logic matched;
    logic overrun;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata;   // [15:0] character
  logic [1:0]        s_tuser;   // [1:0] action
  logic              m_tvalid;
  logic              m_tready;
  logic [7:0]        m_tdata;   // [0] matched, [7:1] zero
  logic              m_tuser;   // [0] pattern_overflow

  glob_wildcard_matcher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------
  // Verdict predictor: a private copy of the pattern store and the NFA.
  // ---------------------------------------------------------------------
  logic [CHAR_W-1:0]    pat_store [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] pat_star;
  int unsigned          pat_len;
  logic [STORE_DEPTH:0] live_pos;     // bit i: first i pattern chars consumed
  logic                 pat_overrun;

  verdict_t verdict_q [$];            // verdicts still owed by the block

  int mismatches  = 0;
  int beats_sent  = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_request       = 0;

  // Stimulus-side view of the pattern, used to build names that match.
  logic [CHAR_W-1:0] gen_pattern [$];

  function automatic logic [CHAR_W-1:0] to_upper(logic [CHAR_W-1:0] c);
    if (c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

  // A live '*' position also makes the next position live; chains of stars
  // propagate because the loop walks upward.
  function automatic logic [STORE_DEPTH:0] star_closure(logic [STORE_DEPTH:0] set);
    for (int i = 0; i < pat_len; i++) begin
      if (set[i] && pat_star[i]) begin
        set[i+1] = 1'b1;
      end
    end
    return set;
  endfunction

  function automatic void advance_nfa(logic [CHAR_W-1:0] c);
    logic [STORE_DEPTH:0] cur;
    logic [STORE_DEPTH:0] nxt;
    logic [CHAR_W-1:0]    uc;
    cur = star_closure(live_pos);
    nxt = '0;
    uc  = to_upper(c);
    for (int i = 0; i < pat_len; i++) begin
      if (cur[i]) begin
        if (pat_star[i]) begin
          nxt[i] = 1'b1;
        end else if (pat_store[i] == QUESTION_CODE || to_upper(pat_store[i]) == uc) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
    live_pos = nxt;
  endfunction

  function automatic void clear_matcher();
    pat_len     = 0;
    pat_star    = '0;
    pat_overrun = 1'b0;
    live_pos    = (STORE_DEPTH+1)'(1);
  endfunction

  // Apply one accepted beat; an end-of-name beat owes one verdict.
  function automatic void glob_step(action_t act, logic [CHAR_W-1:0] c);
    logic [STORE_DEPTH:0] fin;
    verdict_t             v;
    case (act)
      ACT_NEW: begin
        clear_matcher();
      end
      ACT_APPEND: begin
        if (pat_len >= STORE_DEPTH) begin
          pat_overrun = 1'b1;
        end else begin
          pat_store[pat_len] = c;
          pat_star[pat_len]  = (c == STAR_CODE);
          pat_len++;
        end
        live_pos = (STORE_DEPTH+1)'(1);
      end
      ACT_NAME: begin
        advance_nfa(c);
      end
      default: begin
        fin       = star_closure(live_pos);
        v.matched = !pat_overrun && fin[pat_len];
        v.overrun = pat_overrun;
        verdict_q.push_back(v);
        live_pos  = (STORE_DEPTH+1)'(1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker: compare every result beat with the oldest verdict.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result beat with no verdict pending (tdata %h tuser %b)",
                                  m_tdata, m_tuser));
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want.matched) begin
          report_mismatch($sformatf("matched is %b, predicted %b", m_tdata[0], want.matched));
        end
        if (m_tuser !== want.overrun) begin
          report_mismatch($sformatf("pattern_overflow is %b, predicted %b",
                                    m_tuser, want.overrun));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request that is
  // counted here so the block fills up and pushes back on its input.
  // ---------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STUCK_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Driver: offer one beat at a falling edge, after a random idle gap,
  // and hold it until a rising edge sees tready. Predict on acceptance.
  // ---------------------------------------------------------------------
  task automatic send_beat(action_t act, logic [CHAR_W-1:0] ch);
    @(negedge clk);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= ch;
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    glob_step(act, ch);
    beats_sent++;
  endtask

  // Drop valid and hold until every owed verdict has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (verdict_q.size() == 0);
  endtask

  // Mostly letters near the fold range edges, wildcards, and the extremes.
  function automatic logic [CHAR_W-1:0] pick_char(bit in_pattern);
    int r;
    r = $urandom_range(99);
    if (r < 30) return CHAR_W'(LOWER_A + $urandom_range(3));
    if (r < 50) return CHAR_W'(CH_UPPER_A + $urandom_range(3));
    if (r < 62) begin
      case ($urandom_range(7))
        0:       return NUL_CHAR;
        1:       return MAX_CHAR;
        2:       return LOWER_A - 16'd1;
        3:       return LOWER_Z + 16'd1;
        4:       return CH_UPPER_A - 16'd1;
        5:       return CH_LBRACKET;
        6:       return LOWER_Z;
        default: return CH_UPPER_Z;
      endcase
    end
    if (r < (in_pattern ? 77 : 66)) return STAR_CODE;
    if (r < (in_pattern ? 88 : 70)) return QUESTION_CODE;
    return CHAR_W'($urandom_range(MAX_CHAR));
  endfunction

  // Mostly short patterns; one in ten is sized around the store depth and may overflow it.
  task automatic load_pattern();
    int                r;
    int                len;
    logic [CHAR_W-1:0] ch;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(5);
    else if (r < 90) len = $urandom_range(13, 6);
    else len = $urandom_range(STORE_DEPTH + 2, STORE_DEPTH - 1);
    send_beat(ACT_NEW, CHAR_W'($urandom_range(MAX_CHAR)));
    gen_pattern.delete();
    repeat (len) begin
      ch = pick_char(1'b1);
      gen_pattern.push_back(ch);
      send_beat(ACT_APPEND, ch);
    end
  endtask

  // Expand the pattern into a name that should match, then damage it now
  // and then so near misses get exercised too.
  task automatic send_name();
    logic [CHAR_W-1:0] name_q [$];
    logic [CHAR_W-1:0] c;
    int                pos;
    foreach (gen_pattern[i]) begin
      c = gen_pattern[i];
      if (c == STAR_CODE) begin
        repeat ($urandom_range(3)) name_q.push_back(pick_char(1'b0));
      end else if (c == QUESTION_CODE) begin
        name_q.push_back(pick_char(1'b0));
      end else begin
        if ($urandom_range(1)) begin
          if (c >= LOWER_A && c <= LOWER_Z) c = c - CASE_OFFSET;
          else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_OFFSET;
        end
        name_q.push_back(c);
      end
    end
    if ($urandom_range(99) < 30) begin
      pos = (name_q.size() == 0) ? 0 : $urandom_range(name_q.size() - 1);
      case ($urandom_range(2))
        0: begin
          if (name_q.size() > 0) name_q[pos] = pick_char(1'b0);
        end
        1: name_q.insert(pos, pick_char(1'b0));
        default: begin
          if (name_q.size() > 0) name_q.delete(pos);
        end
      endcase
    end
    foreach (name_q[i]) send_beat(ACT_NAME, name_q[i]);
    send_beat(ACT_END, CHAR_W'($urandom_range(MAX_CHAR)));
  endtask

  // Any action with any character; keep the generator's pattern in step.
  task automatic send_noise();
    action_t           act;
    logic [CHAR_W-1:0] c;
    act = action_t'($urandom_range(3));
    c   = $urandom_range(1) ? pick_char(1'b1) : CHAR_W'($urandom_range(MAX_CHAR));
    if (act == ACT_NEW) gen_pattern.delete();
    else if (act == ACT_APPEND) gen_pattern.push_back(c);
    send_beat(act, c);
  endtask

  task automatic run_phase(int goal, int idle_pct, int stall_pct);
    int goal_end;
    int r;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    goal_end = beats_sent + goal;
    load_pattern();
    while (beats_sent < goal_end) begin
      r = $urandom_range(99);
      if (r < 15) begin
        load_pattern();
      end else if (r < 80) begin
        send_name();
      end else if (r < 88) begin
        // cut a name short with a pattern edit or a new pattern
        repeat ($urandom_range(3, 1)) send_beat(ACT_NAME, pick_char(1'b0));
        send_noise();
      end else begin
        send_noise();
      end
    end
    pause_until_drained();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty pattern and empty name, '?' and case folding, code zero and the
  // top code, an append in the middle of a name, and a fold-boundary miss.
  task automatic test_basic_matching();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_beat(ACT_END, MAX_CHAR);          // reset pattern is empty: match
    send_beat(ACT_NEW, MAX_CHAR);
    send_beat(ACT_APPEND, LOWER_A);
    send_beat(ACT_APPEND, QUESTION_CODE);
    send_beat(ACT_APPEND, CH_UPPER_C);
    send_beat(ACT_NAME, CH_UPPER_A);
    send_beat(ACT_NAME, MAX_CHAR);
    send_beat(ACT_NAME, CH_LOWER_C);
    send_beat(ACT_END, NUL_CHAR);          // "a?C" vs "A.c": match
    send_beat(ACT_NAME, CH_LOWER_X);       // dropped by the restart below
    send_beat(ACT_APPEND, NUL_CHAR);
    send_beat(ACT_NAME, LOWER_A);
    send_beat(ACT_NAME, CH_UPPER_Z);
    send_beat(ACT_NAME, CH_UPPER_C);
    send_beat(ACT_NAME, NUL_CHAR);
    send_beat(ACT_END, MAX_CHAR);          // "a?C\0" vs "aZC\0": match
    send_beat(ACT_NAME, CH_UPPER_A);
    send_beat(ACT_NAME, CH_LOWER_B);
    send_beat(ACT_NAME, CH_LBRACKET);      // just past 'Z', not folded
    send_beat(ACT_NAME, NUL_CHAR);
    send_beat(ACT_END, NUL_CHAR);          // miss
    pause_until_drained();
  endtask

  // Fill the store with stars, match an empty name, then overrun it.
  task automatic test_store_overflow();
    send_beat(ACT_NEW, NUL_CHAR);
    repeat (STORE_DEPTH) send_beat(ACT_APPEND, STAR_CODE);
    send_beat(ACT_END, MAX_CHAR);          // only stars, empty name: match
    send_beat(ACT_APPEND, QUESTION_CODE);  // store full: flag overflow
    send_beat(ACT_NAME, LOWER_A);
    send_beat(ACT_END, NUL_CHAR);          // overflowed: never a match
    send_beat(ACT_NEW, MAX_CHAR);          // clears the flag
    send_beat(ACT_END, NUL_CHAR);
    pause_until_drained();
  endtask

  task automatic test_random_no_idle();
    run_phase(PHASE_BEATS, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_phase(PHASE_BEATS, 74, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_phase(PHASE_BEATS, 0, 74);
  endtask

  task automatic test_random_both_idle();
    run_phase(PHASE_BEATS, 20, 20);
  endtask

  // Hold the receiver off while short names keep coming, so the queue
  // fills and s_tready drops; then let it drain completely.
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_beat(ACT_NEW, NUL_CHAR);
    send_beat(ACT_APPEND, QUESTION_CODE);
    gen_pattern.delete();
    gen_pattern.push_back(QUESTION_CODE);
    hold_request = HOLD_CYCLES;
    repeat (40) begin
      send_beat(ACT_NAME, pick_char(1'b0));
      send_beat(ACT_END, CHAR_W'($urandom_range(MAX_CHAR)));
    end
    pause_until_drained();
    repeat (10) send_name();
    pause_until_drained();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    clear_matcher();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_basic_matching();
    test_store_overflow();
    test_random_no_idle();
    test_random_sender_idle();
    test_backpressure();
    test_random_receiver_stall();
    test_random_both_idle();

    // Let the last beats flush through the queue before judging.
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/gwm_pkg.sv
src/gwm_queue.sv
src/gwm_front.sv
src/gwm_back.sv
src/glob_wildcard_matcher.sv
tb/sv/testbench.sv
